### hw/rtl/tcpq_pkg.sv
// shared types and constants for the three-class priority queue
package tcpq_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_SET_PRIO = 2'd1,
		OP_SERVE    = 2'd2,
		OP_LOOKUP   = 2'd3
	} tcpq_op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_PRIO  = 3'd4
	} tcpq_status_t;

	// class codes
	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_LOW  = 2'd1;

	// action broadcast to the cell row at the end of an operation
	typedef enum logic [1:0] {
		CMT_NONE = 2'd0,
		CMT_NEW  = 2'd1,
		CMT_MOVE = 2'd2,
		CMT_FREE = 2'd3
	} tcpq_act_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SWEEP  = 2'd1,
		S_FINISH = 2'd2
	} tcpq_state_t;

	// request item
	typedef struct packed {
		tcpq_op_t    op;
		logic [31:0] key;
		logic [1:0]  new_priority;
	} tcpq_req_t;

	// result item
	typedef struct packed {
		tcpq_status_t status;
		logic [31:0]  found_key;
		logic [31:0]  arrival_number;
		logic [1:0]   entry_priority;
	} tcpq_rsp_t;

	// best candidate so far, walking down the cell row
	typedef struct packed {
		logic        found;
		logic [1:0]  cls;
		logic [31:0] order;
		logic [31:0] arrival;
	} tcpq_tok_t;

	// update for one cell
	typedef struct packed {
		tcpq_act_t   act;
		logic [1:0]  cls;
		logic [31:0] order;
		logic [31:0] arrival;
	} tcpq_cmt_t;

endpackage

### hw/rtl/three_class_priority_queue_unit.sv
// three-class strict priority queue built as a row of slot cells
//
// Requests come in on req_item (op, key, new_priority) under req_valid and
// req_stall; each gives exactly one result on rsp_item under rsp_valid and
// rsp_stall. Ops: register a key into the low class, move a key to another
// class, serve the oldest entry of the highest class, look a key up.
// An accepted item launches a candidate that walks the cell row one slot
// per cycle until it reaches the row tail; a finishing step then decides,
// updates the chosen slot and loads the output register.
// A new item is taken only once the finishing step has returned the
// block to idle, so the walk down the row sets the pace. req_stall is
// high while an item is in work.
// A waiting result does not hold off the next item; only the finishing
// step waits while the output register is full and stalled.
// Reset empties every slot, sets the next arrival number to one and the
// next order stamp to zero, and drops rsp_valid.
module three_class_priority_queue_unit #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tcpq_pkg::tcpq_req_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tcpq_pkg::tcpq_rsp_t rsp_item
);
	import tcpq_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	tcpq_state_t         state_q, state_d;
	logic [IW-1:0]       cnt_q;
	tcpq_op_t            op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [1:0]          prio_q;
	logic [31:0]         next_arrival_q;
	logic [31:0]         next_order_q;
	logic                out_valid_q;
	tcpq_rsp_t           out_q;

	tcpq_tok_t           tok_w  [CAPACITY+1];
	logic [KEY_BITS-1:0] tkey_w [CAPACITY+1];
	logic [IW-1:0]       tidx_w [CAPACITY+1];
	logic [CAPACITY-1:0] cell_vld;

	logic                accept;
	logic                out_free;
	logic                fire;
	logic [63:0]         req_key_ext;
	logic [63:0]         key_q_ext;
	logic [63:0]         tail_key_ext;
	tcpq_rsp_t           rsp_d;
	tcpq_cmt_t           cmt_d;
	tcpq_cmt_t           cmt;
	logic                bump_arrival;
	logic                bump_order;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign fire      = (state_q == S_FINISH) && out_free;
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	// key kept to KEY_BITS bits, shown as 32 bits
	assign req_key_ext  = {32'b0, req_item.key};
	assign key_q_ext    = 64'(key_q);
	assign tail_key_ext = 64'(tkey_w[CAPACITY]);

	// an empty candidate enters the head of the row
	assign tok_w[0]  = '0;
	assign tkey_w[0] = '0;
	assign tidx_w[0] = '0;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		tcpq_cell #(
			.KEY_BITS (KEY_BITS),
			.IW       (IW),
			.IDX      (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op_q),
			.key         (key_q),
			.tok_in      (tok_w[i]),
			.tok_key_in  (tkey_w[i]),
			.tok_idx_in  (tidx_w[i]),
			.tok_out     (tok_w[i+1]),
			.tok_key_out (tkey_w[i+1]),
			.tok_idx_out (tidx_w[i+1]),
			.cmt         (cmt),
			.cmt_idx     (tidx_w[CAPACITY]),
			.vld         (cell_vld[i])
		);
	end

	// decide result and slot update from the candidate at the row tail
	always_comb begin
		rsp_d.status         = ST_OK;
		rsp_d.found_key      = tail_key_ext[31:0];
		rsp_d.arrival_number = tok_w[CAPACITY].arrival;
		rsp_d.entry_priority = tok_w[CAPACITY].cls;
		cmt_d.act            = CMT_NONE;
		cmt_d.cls            = prio_q;
		cmt_d.order          = next_order_q;
		cmt_d.arrival        = next_arrival_q;
		bump_arrival         = 1'b0;
		bump_order           = 1'b0;
		case (op_q)
			OP_REGISTER: begin
				rsp_d.found_key = key_q_ext[31:0];
				if (!tok_w[CAPACITY].found) begin
					rsp_d.status         = ST_FULL;
					rsp_d.arrival_number = '0;
					rsp_d.entry_priority = CLS_NONE;
				end else begin
					rsp_d.arrival_number = next_arrival_q;
					rsp_d.entry_priority = CLS_LOW;
					cmt_d.act            = CMT_NEW;
					cmt_d.cls            = CLS_LOW;
					bump_arrival         = 1'b1;
					bump_order           = 1'b1;
				end
			end
			OP_SET_PRIO: begin
				if (!tok_w[CAPACITY].found) begin
					rsp_d.status         = ST_NOT_FOUND;
					rsp_d.found_key      = key_q_ext[31:0];
					rsp_d.arrival_number = '0;
					rsp_d.entry_priority = CLS_NONE;
				end else if (prio_q == CLS_NONE) begin
					rsp_d.status = ST_BAD_PRIO;
				end else begin
					rsp_d.entry_priority = prio_q;
					cmt_d.act            = CMT_MOVE;
					bump_order           = 1'b1;
				end
			end
			OP_SERVE: begin
				if (!tok_w[CAPACITY].found) begin
					rsp_d.status         = ST_EMPTY;
					rsp_d.found_key      = '0;
					rsp_d.arrival_number = '0;
					rsp_d.entry_priority = CLS_NONE;
				end else begin
					cmt_d.act = CMT_FREE;
				end
			end
			default: begin
				if (!tok_w[CAPACITY].found) begin
					rsp_d.status         = ST_NOT_FOUND;
					rsp_d.found_key      = key_q_ext[31:0];
					rsp_d.arrival_number = '0;
					rsp_d.entry_priority = CLS_NONE;
				end
			end
		endcase
	end

	// slot update only on the finishing cycle
	always_comb begin
		cmt     = cmt_d;
		cmt.act = fire ? cmt_d.act : CMT_NONE;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_SWEEP;
			end
			S_SWEEP: begin
				if (cnt_q == IW'(CAPACITY - 1)) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			next_arrival_q <= 32'd1;
			next_order_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SWEEP) begin
				cnt_q <= cnt_q + IW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (fire && bump_arrival) next_arrival_q <= next_arrival_q + 32'd1;
			if (fire && bump_order) next_order_q <= next_order_q + 32'd1;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_item.op;
			key_q  <= req_key_ext[KEY_BITS-1:0];
			prio_q <= req_item.new_priority;
		end
		if (fire) out_q <= rsp_d;
	end

	// finishing always hands the block back to idle
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q == S_IDLE))
		else $error("finish step did not return to idle");

	// walk counter stays inside the row
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (cnt_q <= IW'(CAPACITY - 1)))
		else $error("walk counter beyond the cell row");

	// arrival numbers advance only on a register step
	a_arrival_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(next_arrival_q != $past(next_arrival_q)) |->
			($past(state_q) == S_FINISH && $past(op_q) == OP_REGISTER))
		else $error("arrival number moved outside a register step");

	// table full is only reported when every slot is taken
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp_d.status == ST_FULL) |-> (&cell_vld))
		else $error("table full reported with a free slot");

endmodule

### hw/rtl/tcpq_cell.sv
// one table slot of the queue with its stage of the candidate walk
module tcpq_cell #(
	parameter int KEY_BITS = 32,
	parameter int IW       = 4,
	parameter int IDX      = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcpq_pkg::tcpq_op_t   op,
	input  logic [KEY_BITS-1:0]  key,
	input  tcpq_pkg::tcpq_tok_t  tok_in,
	input  logic [KEY_BITS-1:0]  tok_key_in,
	input  logic [IW-1:0]        tok_idx_in,
	output tcpq_pkg::tcpq_tok_t  tok_out,
	output logic [KEY_BITS-1:0]  tok_key_out,
	output logic [IW-1:0]        tok_idx_out,
	input  tcpq_pkg::tcpq_cmt_t  cmt,
	input  logic [IW-1:0]        cmt_idx,
	output logic                 vld
);
	import tcpq_pkg::*;

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         arrival_q;
	logic [1:0]          cls_q;
	logic [31:0]         order_q;

	logic [31:0]         order_diff;
	logic                rank_win;
	logic                better;
	logic                sel;

	assign vld = valid_q;
	assign sel = (cmt_idx == IW'(IDX));

	// higher class wins, then the older stamp by serial arithmetic
	assign order_diff = order_q - tok_in.order;
	assign rank_win   = !tok_in.found || (cls_q > tok_in.cls) ||
		((cls_q == tok_in.cls) && order_diff[31]);

	// does this slot replace the incoming candidate
	always_comb begin
		case (op)
			OP_REGISTER: better = !valid_q && !tok_in.found;
			OP_SERVE: better = valid_q && rank_win;
			OP_SET_PRIO, OP_LOOKUP: better = valid_q && (key_q == key) && rank_win;
			default: better = 1'b0;
		endcase
	end

	// candidate stage towards the next cell
	always_ff @(posedge clk) begin
		if (better) begin
			tok_out.found   <= 1'b1;
			tok_out.cls     <= cls_q;
			tok_out.order   <= order_q;
			tok_out.arrival <= arrival_q;
			tok_key_out     <= key_q;
			tok_idx_out     <= IW'(IDX);
		end else begin
			tok_out     <= tok_in;
			tok_key_out <= tok_key_in;
			tok_idx_out <= tok_idx_in;
		end
	end

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			case (cmt.act)
				CMT_NEW: valid_q <= 1'b1;
				CMT_FREE: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmt.act)
				CMT_NEW: begin
					key_q     <= key;
					arrival_q <= cmt.arrival;
					cls_q     <= cmt.cls;
					order_q   <= cmt.order;
				end
				CMT_MOVE: begin
					cls_q   <= cmt.cls;
					order_q <= cmt.order;
				end
				default: begin
					cls_q <= cls_q;
				end
			endcase
		end
	end

endmodule

### verif/three_class_priority_queue_unit_tb.sv
// self-checking testbench for the three-class priority queue unit
module three_class_priority_queue_unit_tb;
	import tcpq_pkg::*;

	localparam int          SLOTS     = 16;
	localparam int          POOL      = 6;
	localparam int          HOLD_LONG = 300;
	localparam int          TAIL_WAIT = 40;
	localparam logic [1:0]  CLS_MED   = 2'd2;
	localparam logic [1:0]  CLS_HIGH  = 2'd3;
	localparam int          MODE_FILL  = 0;
	localparam int          MODE_DRAIN = 1;
	localparam int          MODE_MIX   = 2;

	// one row of the directed sequence; reps registers consecutive keys
	typedef struct packed {
		tcpq_op_t    op;
		logic [31:0] key;
		logic [1:0]  prio;
		int          reps;
		bit          typed;
		tcpq_rsp_t   want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	tcpq_req_t req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	tcpq_rsp_t rsp_item;

	// shadow of the queue contents
	bit          ent_used [SLOTS];
	logic [31:0] ent_key [SLOTS];
	logic [31:0] ent_arrival [SLOTS];
	logic [1:0]  ent_cls [SLOTS];
	logic [31:0] ent_stamp [SLOTS];
	logic [31:0] arrival_ctr;
	logic [31:0] stamp_ctr;

	tcpq_rsp_t   pending_results [$];
	logic [31:0] key_pool [POOL];
	dir_row_t    dir_tab [17];
	int          err_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	three_class_priority_queue_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// serial-number comparison of order stamps
	function automatic bit stamp_older(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// oldest entry of a class, optionally restricted to one key
	function automatic int oldest_in_class(logic [1:0] cls, bit by_key, logic [31:0] key);
		int best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!ent_used[i] || ent_cls[i] != cls)
				continue;
			if (by_key && ent_key[i] != key)
				continue;
			if (best < 0 || stamp_older(ent_stamp[i], ent_stamp[best]))
				best = i;
		end
		return best;
	endfunction

	// first entry holding the key, high class first
	function automatic int find_entry(logic [31:0] key);
		int idx = -1;
		for (int c = CLS_HIGH; c >= CLS_LOW; c--) begin
			idx = oldest_in_class(2'(c), 1'b1, key);
			if (idx >= 0)
				break;
		end
		return idx;
	endfunction

	// apply one request to the shadow queue and return its result
	function automatic tcpq_rsp_t apply_request(tcpq_req_t req);
		tcpq_rsp_t res;
		int        idx = -1;
		res = '{ST_OK, 32'h0, 32'h0, CLS_NONE};
		case (req.op)
			OP_REGISTER: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!ent_used[i]) begin
						idx = i;
						break;
					end
				end
				if (idx < 0) begin
					res = '{ST_FULL, req.key, 32'h0, CLS_NONE};
				end else begin
					ent_used[idx]    = 1'b1;
					ent_key[idx]     = req.key;
					ent_arrival[idx] = arrival_ctr;
					ent_cls[idx]     = CLS_LOW;
					ent_stamp[idx]   = stamp_ctr;
					arrival_ctr++;
					stamp_ctr++;
					res = '{ST_OK, req.key, ent_arrival[idx], CLS_LOW};
				end
			end
			OP_SET_PRIO: begin
				idx = find_entry(req.key);
				if (idx < 0) begin
					res = '{ST_NOT_FOUND, req.key, 32'h0, CLS_NONE};
				end else if (req.new_priority == CLS_NONE) begin
					res = '{ST_BAD_PRIO, ent_key[idx], ent_arrival[idx], ent_cls[idx]};
				end else begin
					ent_cls[idx]   = req.new_priority;
					ent_stamp[idx] = stamp_ctr;
					stamp_ctr++;
					res = '{ST_OK, ent_key[idx], ent_arrival[idx], req.new_priority};
				end
			end
			OP_SERVE: begin
				for (int c = CLS_HIGH; c >= CLS_LOW; c--) begin
					idx = oldest_in_class(2'(c), 1'b0, 32'h0);
					if (idx >= 0)
						break;
				end
				if (idx < 0) begin
					res = '{ST_EMPTY, 32'h0, 32'h0, CLS_NONE};
				end else begin
					ent_used[idx] = 1'b0;
					res = '{ST_OK, ent_key[idx], ent_arrival[idx], ent_cls[idx]};
				end
			end
			default: begin
				idx = find_entry(req.key);
				if (idx < 0)
					res = '{ST_NOT_FOUND, req.key, 32'h0, CLS_NONE};
				else
					res = '{ST_OK, ent_key[idx], ent_arrival[idx], ent_cls[idx]};
			end
		endcase
		return res;
	endfunction

	// random request, op mix biased by mode, keys mostly from the pool
	function automatic tcpq_req_t rand_request(int mode);
		tcpq_req_t r;
		int        dice;
		int        t_reg;
		int        t_set;
		int        t_srv;
		dice = $urandom_range(99);
		case (mode)
			MODE_FILL:  begin t_reg = 55; t_set = 75; t_srv = 85; end
			MODE_DRAIN: begin t_reg = 10; t_set = 25; t_srv = 80; end
			default:    begin t_reg = 30; t_set = 55; t_srv = 80; end
		endcase
		if (dice < t_reg)
			r.op = OP_REGISTER;
		else if (dice < t_set)
			r.op = OP_SET_PRIO;
		else if (dice < t_srv)
			r.op = OP_SERVE;
		else
			r.op = OP_LOOKUP;
		r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL - 1)] : $urandom;
		r.new_priority = 2'($urandom_range(3));
		return r;
	endfunction

	// offer one item, wait for acceptance, then record its expected result
	task automatic send_item(input tcpq_req_t req, input bit typed, input tcpq_rsp_t want);
		tcpq_rsp_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= req;
		do
			@(posedge clk);
		while (req_stall);
		pred = apply_request(req);
		pending_results.push_back(typed ? want : pred);
	endtask

	// hold the sender until every outstanding result has arrived
	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// compare one accepted result with the oldest expectation
	task automatic check_result(input tcpq_rsp_t got);
		tcpq_rsp_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result item: status %0d key %h", got.status, got.found_key);
			err_cnt++;
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			err_cnt++;
		end
		if (got.found_key !== want.found_key) begin
			$error("found_key: expected %h, got %h", want.found_key, got.found_key);
			err_cnt++;
		end
		if (got.arrival_number !== want.arrival_number) begin
			$error("arrival_number: expected %0d, got %0d", want.arrival_number,
				got.arrival_number);
			err_cnt++;
		end
		if (got.entry_priority !== want.entry_priority) begin
			$error("entry_priority: expected %0d, got %0d", want.entry_priority,
				got.entry_priority);
			err_cnt++;
		end
	endtask

	// result side: sample at the rising edge, stall decision at the falling edge
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				check_result(rsp_item);
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_LONG;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("three_class_priority_queue_unit_tb: FAIL");
		$finish;
	end

	// stimulus
	initial begin
		tcpq_req_t req;
		int        idle_tab [4];
		int        stall_tab [4];
		int        mode;
		idle_tab  = '{0, 67, 0, 18};
		stall_tab = '{0, 0, 67, 18};
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_item  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			ent_used[i] = 1'b0;
		end
		arrival_ctr = 32'd1;
		stamp_ctr   = 32'd0;
		for (int i = 0; i < POOL; i++) begin
			key_pool[i] = $urandom;
		end

		// directed part: empty queue, extremes of key, bad class, full table,
		// move into the same class and strict class order on serve
		dir_tab = '{
			'{OP_SERVE,    32'h0000_0000, CLS_NONE, 1, 1'b1,
				'{ST_EMPTY, 32'h0, 32'h0, CLS_NONE}},
			'{OP_LOOKUP,   32'h0000_0000, CLS_NONE, 1, 1'b1,
				'{ST_NOT_FOUND, 32'h0, 32'h0, CLS_NONE}},
			'{OP_SET_PRIO, 32'hFFFF_FFFF, CLS_NONE, 1, 1'b1,
				'{ST_NOT_FOUND, 32'hFFFF_FFFF, 32'h0, CLS_NONE}},
			'{OP_REGISTER, 32'hFFFF_FFFF, CLS_HIGH, 1, 1'b1,
				'{ST_OK, 32'hFFFF_FFFF, 32'd1, CLS_LOW}},
			'{OP_REGISTER, 32'h0000_0000, CLS_NONE, 1, 1'b1,
				'{ST_OK, 32'h0, 32'd2, CLS_LOW}},
			'{OP_SET_PRIO, 32'hFFFF_FFFF, CLS_NONE, 1, 1'b1,
				'{ST_BAD_PRIO, 32'hFFFF_FFFF, 32'd1, CLS_LOW}},
			'{OP_SET_PRIO, 32'hFFFF_FFFF, CLS_HIGH, 1, 1'b1,
				'{ST_OK, 32'hFFFF_FFFF, 32'd1, CLS_HIGH}},
			'{OP_SET_PRIO, 32'h0000_0000, CLS_MED,  1, 1'b0, '0},
			'{OP_SET_PRIO, 32'h0000_0000, CLS_MED,  1, 1'b0, '0},
			'{OP_REGISTER, 32'h5555_5555, CLS_NONE, 14, 1'b0, '0},
			'{OP_REGISTER, 32'hAAAA_AAAA, CLS_LOW,  1, 1'b1,
				'{ST_FULL, 32'hAAAA_AAAA, 32'h0, CLS_NONE}},
			'{OP_LOOKUP,   32'h0000_0000, CLS_NONE, 1, 1'b0, '0},
			'{OP_SERVE,    32'h0000_0000, CLS_NONE, 1, 1'b0, '0},
			'{OP_SET_PRIO, 32'h5555_5555, CLS_LOW,  1, 1'b0, '0},
			'{OP_SERVE,    32'hFFFF_FFFF, CLS_HIGH, 1, 1'b0, '0},
			'{OP_SERVE,    32'h0000_0000, CLS_NONE, 1, 1'b0, '0},
			'{OP_LOOKUP,   32'hAAAA_AAAA, CLS_NONE, 1, 1'b1,
				'{ST_NOT_FOUND, 32'hAAAA_AAAA, 32'h0, CLS_NONE}}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[r]) begin
			for (int k = 0; k < dir_tab[r].reps; k++) begin
				req.op           = dir_tab[r].op;
				req.key          = dir_tab[r].key + k;
				req.new_priority = dir_tab[r].prio;
				send_item(req, dir_tab[r].typed, dir_tab[r].want);
			end
		end

		// random part over the idling phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			mode = MODE_MIX;
			for (int n = 0; n < 250; n++) begin
				if (n % 40 == 0) begin
					mode = $urandom_range(2);
					key_pool[$urandom_range(POOL - 1)] = $urandom;
				end
				send_item(rand_request(mode), 1'b0, '0);
			end
			if (ph == 0) begin
				// long receiver hold-off while items keep coming
				hold_req = 1'b1;
				for (int n = 0; n < 24; n++) begin
					send_item(rand_request(MODE_FILL), 1'b0, '0);
				end
			end
			@(negedge clk);
			req_valid <= 1'b0;
			drain_results();
		end

		// wind down
		recv_stall_pct = 0;
		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("three_class_priority_queue_unit_tb: PASS");
		else
			$display("three_class_priority_queue_unit_tb: FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_cell.sv
hw/rtl/three_class_priority_queue_unit.sv
verif/three_class_priority_queue_unit_tb.sv
